// ===== design/sttc_pkg.sv =====
// ----------------------------------------------------------------------------
// sttc_pkg
// shared types and constants of the segment / triangle crossing test
// ----------------------------------------------------------------------------
package sttc_pkg;

   localparam int FIELD_BITS = 63;
   localparam int COEF_BITS  = 21;
   localparam int COEF_FRAC  = 12;
   localparam int LIMIT_BITS = 20;
   localparam int CSR_INDEX_BITS = 3;
   localparam int NUM_STAGES = 8;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_X       = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_Y       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_Z       = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRANSLATION = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEAR_LIMIT  = 3'd4;

   localparam logic [FIELD_BITS-1:0] ROW_X_RESET = 63'd4096;
   localparam logic [FIELD_BITS-1:0] ROW_Y_RESET = 63'd8589934592;
   localparam logic [FIELD_BITS-1:0] ROW_Z_RESET = 63'd18014398509481984;
   localparam logic [FIELD_BITS-1:0] TRANSLATION_RESET = 63'd0;
   localparam logic [LIMIT_BITS-1:0] NEAR_LIMIT_RESET  = 20'd768;

   typedef enum logic [2:0] {
      CAUSE_MISS       = 3'd0,
      CAUSE_NO_MOTION  = 3'd1,
      CAUSE_NEAR       = 3'd2,
      CAUSE_CROSS      = 3'd3,
      CAUSE_DEGENERATE = 3'd4
   } cause_type;

   typedef struct packed {
      logic no_motion;
      logic near;
   } flags_type;

endpackage

// ===== design/sttc_xform.sv =====
// ----------------------------------------------------------------------------
// sttc_xform
// stages 1-2: affine transform of the three corners, round and saturate
// ----------------------------------------------------------------------------
module sttc_xform import sttc_pkg::*; #(
   parameter int COORD_BITS = 21
) (
   input  logic                          clock,
   input  logic [1:0]                    en,
   input  logic [FIELD_BITS-1:0]         segment_start,
   input  logic [FIELD_BITS-1:0]         segment_end,
   input  logic [FIELD_BITS-1:0]         vertex_a,
   input  logic [FIELD_BITS-1:0]         vertex_b,
   input  logic [FIELD_BITS-1:0]         vertex_c,
   input  logic [FIELD_BITS-1:0]         row_x,
   input  logic [FIELD_BITS-1:0]         row_y,
   input  logic [FIELD_BITS-1:0]         row_z,
   input  logic [FIELD_BITS-1:0]         translation,
   output logic signed [COORD_BITS-1:0]  s_o [3],
   output logic signed [COORD_BITS-1:0]  e_o [3],
   output logic signed [COORD_BITS-1:0]  a_o [3],
   output logic signed [COORD_BITS-1:0]  b_o [3],
   output logic signed [COORD_BITS-1:0]  c_o [3],
   output logic                          no_motion_o
);

   localparam int C  = COORD_BITS;
   localparam int PW = COEF_BITS + C;
   localparam int AW = PW + 2;
   localparam logic signed [AW-1:0] SAT_HI = AW'((1 << (C - 1)) - 1);
   localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);
   localparam logic signed [AW-1:0] HALF   = AW'(1 << (COEF_FRAC - 1));

   logic [FIELD_BITS-1:0] vw [3];
   logic [FIELD_BITS-1:0] rw [3];

   logic signed [PW-1:0] prod_in [3][3][3];
   logic signed [PW-1:0] prod_ff [3][3][3];
   logic signed [C-1:0]  s1_in [3], e1_in [3];
   logic signed [C-1:0]  s1_ff [3], e1_ff [3];
   logic                 nomo_in, nomo1_ff;

   logic signed [C-1:0]  mapped_in [3][3];
   logic signed [C-1:0]  mapped_ff [3][3];
   logic signed [C-1:0]  s2_ff [3], e2_ff [3];
   logic                 nomo2_ff;

   assign vw[0] = vertex_a;
   assign vw[1] = vertex_b;
   assign vw[2] = vertex_c;
   assign rw[0] = row_x;
   assign rw[1] = row_y;
   assign rw[2] = row_z;

   // stage 1: coefficient products
   always_comb begin
      logic signed [COEF_BITS-1:0] cf;
      logic signed [C-1:0]         vv;
      for (int p = 0; p < 3; p++) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               cf = $signed(rw[i][j*COEF_BITS +: COEF_BITS]);
               vv = $signed(vw[p][j*C +: C]);
               prod_in[p][i][j] = PW'(cf) * PW'(vv);
            end
         end
      end
      for (int i = 0; i < 3; i++) begin
         s1_in[i] = $signed(segment_start[i*C +: C]);
         e1_in[i] = $signed(segment_end[i*C +: C]);
      end
      nomo_in = (s1_in[0] == e1_in[0]) && (s1_in[1] == e1_in[1]) &&
                (s1_in[2] == e1_in[2]);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         prod_ff  <= prod_in;
         s1_ff    <= s1_in;
         e1_ff    <= e1_in;
         nomo1_ff <= nomo_in;
      end
   end

   // stage 2: accumulate, round half up, saturate
   always_comb begin
      logic signed [C-1:0]  tr;
      logic signed [AW-1:0] acc;
      logic signed [AW-1:0] sh;
      for (int p = 0; p < 3; p++) begin
         for (int i = 0; i < 3; i++) begin
            tr  = $signed(translation[i*C +: C]);
            acc = (AW'(tr) <<< COEF_FRAC) + AW'(prod_ff[p][i][0]) +
                  AW'(prod_ff[p][i][1]) + AW'(prod_ff[p][i][2]) + HALF;
            sh  = acc >>> COEF_FRAC;
            if (sh > SAT_HI) begin
               mapped_in[p][i] = SAT_HI[C-1:0];
            end else if (sh < SAT_LO) begin
               mapped_in[p][i] = SAT_LO[C-1:0];
            end else begin
               mapped_in[p][i] = sh[C-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         mapped_ff <= mapped_in;
         s2_ff     <= s1_ff;
         e2_ff     <= e1_ff;
         nomo2_ff  <= nomo1_ff;
      end
   end

   assign s_o = s2_ff;
   assign e_o = e2_ff;
   assign a_o = mapped_ff[0];
   assign b_o = mapped_ff[1];
   assign c_o = mapped_ff[2];
   assign no_motion_o = nomo2_ff;

endmodule

// ===== design/sttc_geom.sv =====
// ----------------------------------------------------------------------------
// sttc_geom
// stages 3-5: edge vectors, distance to first corner, cross products
// ----------------------------------------------------------------------------
module sttc_geom import sttc_pkg::*; #(
   parameter int COORD_BITS = 21
) (
   input  logic                            clock,
   input  logic [2:0]                      en,
   input  logic signed [COORD_BITS-1:0]    s_i [3],
   input  logic signed [COORD_BITS-1:0]    e_i [3],
   input  logic signed [COORD_BITS-1:0]    a_i [3],
   input  logic signed [COORD_BITS-1:0]    b_i [3],
   input  logic signed [COORD_BITS-1:0]    c_i [3],
   input  logic                            no_motion_i,
   input  logic [LIMIT_BITS-1:0]           near_limit,
   output logic signed [COORD_BITS:0]      d_o [3],
   output logic signed [COORD_BITS:0]      r_o [3],
   output logic signed [2*COORD_BITS+2:0]  n_o [3],
   output logic signed [2*COORD_BITS+2:0]  q_o [3],
   output logic signed [2*COORD_BITS+2:0]  w_o [3],
   output flags_type                       flags_o
);

   localparam int D  = COORD_BITS + 1;
   localparam int DW = 2*D + 2;
   localparam int LW = (DW > 2*LIMIT_BITS + 1) ? DW : 2*LIMIT_BITS + 1;

   // stage 3 registers
   logic signed [D-1:0] d3_ff [3], e13_ff [3], e23_ff [3], r3_ff [3], k3_ff [3];
   logic                nomo3_ff;
   // stage 4 registers
   logic signed [2*D-1:0] kk_ff [3];
   logic signed [2*D-1:0] pp_ff [3][3], pn_ff [3][3];
   logic signed [D-1:0]   d4_ff [3], r4_ff [3];
   logic                  nomo4_ff;
   // stage 5 registers
   logic signed [2*D:0]   x_ff [3][3];
   logic signed [D-1:0]   d5_ff [3], r5_ff [3];
   flags_type             flags5_ff;

   logic signed [D-1:0]   xs [3][3], ys [3][3];
   logic signed [2*D-1:0] pp_in [3][3], pn_in [3][3], kk_in [3];
   logic signed [2*D:0]   x_in [3][3];
   logic signed [LW-1:0]  dist2;
   logic signed [LW-1:0]  lim2;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int i = 0; i < 3; i++) begin
            d3_ff[i]  <= D'(s_i[i]) - D'(e_i[i]);
            e13_ff[i] <= D'(b_i[i]) - D'(a_i[i]);
            e23_ff[i] <= D'(c_i[i]) - D'(a_i[i]);
            r3_ff[i]  <= D'(s_i[i]) - D'(a_i[i]);
            k3_ff[i]  <= D'(e_i[i]) - D'(a_i[i]);
         end
         nomo3_ff <= no_motion_i;
      end
   end

   // cross operands: normal e1 x e2, r x e2, e1 x r
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         xs[0][i] = e13_ff[i];  ys[0][i] = e23_ff[i];
         xs[1][i] = r3_ff[i];   ys[1][i] = e23_ff[i];
         xs[2][i] = e13_ff[i];  ys[2][i] = r3_ff[i];
      end
      for (int m = 0; m < 3; m++) begin
         for (int i = 0; i < 3; i++) begin
            pp_in[m][i] = (2*D)'(xs[m][(i+1)%3]) * (2*D)'(ys[m][(i+2)%3]);
            pn_in[m][i] = (2*D)'(xs[m][(i+2)%3]) * (2*D)'(ys[m][(i+1)%3]);
         end
      end
      for (int i = 0; i < 3; i++) begin
         kk_in[i] = (2*D)'(k3_ff[i]) * (2*D)'(k3_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         pp_ff    <= pp_in;
         pn_ff    <= pn_in;
         kk_ff    <= kk_in;
         d4_ff    <= d3_ff;
         r4_ff    <= r3_ff;
         nomo4_ff <= nomo3_ff;
      end
   end

   always_comb begin
      for (int m = 0; m < 3; m++) begin
         for (int i = 0; i < 3; i++) begin
            x_in[m][i] = (2*D+1)'(pp_ff[m][i]) - (2*D+1)'(pn_ff[m][i]);
         end
      end
      dist2 = LW'(kk_ff[0]) + LW'(kk_ff[1]) + LW'(kk_ff[2]);
      lim2  = $signed(LW'({1'b0, near_limit}) * LW'({1'b0, near_limit}));
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         x_ff                <= x_in;
         d5_ff               <= d4_ff;
         r5_ff               <= r4_ff;
         flags5_ff.no_motion <= nomo4_ff;
         flags5_ff.near      <= dist2 < lim2;
      end
   end

   assign d_o = d5_ff;
   assign r_o = r5_ff;
   assign n_o = x_ff[0];
   assign q_o = x_ff[1];
   assign w_o = x_ff[2];
   assign flags_o = flags5_ff;

endmodule

// ===== design/sttc_solve.sv =====
// ----------------------------------------------------------------------------
// sttc_solve
// stages 6-8: cramer numerators and determinant, range tests, result
// ----------------------------------------------------------------------------
module sttc_solve import sttc_pkg::*; #(
   parameter int COORD_BITS = 21
) (
   input  logic                            clock,
   input  logic [2:0]                      en,
   input  logic signed [COORD_BITS:0]      d_i [3],
   input  logic signed [COORD_BITS:0]      r_i [3],
   input  logic signed [2*COORD_BITS+2:0]  n_i [3],
   input  logic signed [2*COORD_BITS+2:0]  q_i [3],
   input  logic signed [2*COORD_BITS+2:0]  w_i [3],
   input  flags_type                       flags_i,
   output logic                            hit_o,
   output cause_type                       cause_o
);

   localparam int D  = COORD_BITS + 1;
   localparam int PD = 3*D + 1;
   localparam int SW = PD + 2;
   localparam int AW = SW + 2;

   logic signed [PD-1:0] dn_ff [3], rn_ff [3], dq_ff [3], dw_ff [3];
   flags_type            flags6_ff, flags7_ff;
   logic signed [SW-1:0] det_ff, tn_ff, un_ff, vn_ff;
   logic                 hit_ff;
   cause_type            cause_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int i = 0; i < 3; i++) begin
            dn_ff[i] <= PD'(d_i[i]) * PD'(n_i[i]);
            rn_ff[i] <= PD'(r_i[i]) * PD'(n_i[i]);
            dq_ff[i] <= PD'(d_i[i]) * PD'(q_i[i]);
            dw_ff[i] <= PD'(d_i[i]) * PD'(w_i[i]);
         end
         flags6_ff <= flags_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         det_ff    <= SW'(dn_ff[0]) + SW'(dn_ff[1]) + SW'(dn_ff[2]);
         tn_ff     <= SW'(rn_ff[0]) + SW'(rn_ff[1]) + SW'(rn_ff[2]);
         un_ff     <= SW'(dq_ff[0]) + SW'(dq_ff[1]) + SW'(dq_ff[2]);
         vn_ff     <= SW'(dw_ff[0]) + SW'(dw_ff[1]) + SW'(dw_ff[2]);
         flags7_ff <= flags6_ff;
      end
   end

   logic signed [AW-1:0] det_a, tn_a, un_a, vn_a;
   logic                 in_range;
   logic                 hit_in;
   cause_type            cause_in;

   // flip signs so the determinant is positive, then inclusive range tests
   always_comb begin
      if (det_ff < 0) begin
         det_a = -AW'(det_ff);
         tn_a  = -AW'(tn_ff);
         un_a  = -AW'(un_ff);
         vn_a  = -AW'(vn_ff);
      end else begin
         det_a = AW'(det_ff);
         tn_a  = AW'(tn_ff);
         un_a  = AW'(un_ff);
         vn_a  = AW'(vn_ff);
      end
      in_range = (tn_a >= 0) && (tn_a <= det_a) && (un_a >= 0) && (un_a <= det_a) &&
                 (vn_a >= 0) && (vn_a <= det_a) && ((un_a + vn_a) <= det_a);
      if (flags7_ff.no_motion) begin
         hit_in = 1'b0;  cause_in = CAUSE_NO_MOTION;
      end else if (flags7_ff.near) begin
         hit_in = 1'b1;  cause_in = CAUSE_NEAR;
      end else if (det_ff == 0) begin
         hit_in = 1'b0;  cause_in = CAUSE_DEGENERATE;
      end else if (in_range) begin
         hit_in = 1'b1;  cause_in = CAUSE_CROSS;
      end else begin
         hit_in = 1'b0;  cause_in = CAUSE_MISS;
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         hit_ff   <= hit_in;
         cause_ff <= cause_in;
      end
   end

   assign hit_o   = hit_ff;
   assign cause_o = cause_ff;

endmodule

// ===== design/segment_triangle_crossing_test_top.sv =====
// path: eight register stages from the request accept edge to rsp_valid, the
//   first loads at the accept edge
// throughput: one request per cycle through the eight stages, barring stalls
// stalls: a full stage holds while the stage after it is full and stalled
// reset: synchronous, clears stage valid bits and loads default registers
// ----------------------------------------------------------------------------
// segment_triangle_crossing_test_top
// segment versus triangle crossing test with affine corner transform
// ----------------------------------------------------------------------------
module segment_triangle_crossing_test_top import sttc_pkg::*; #(
   parameter int COORD_BITS = 21
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [FIELD_BITS-1:0]     req_segment_start,
   input  logic [FIELD_BITS-1:0]     req_segment_end,
   input  logic [FIELD_BITS-1:0]     req_vertex_a,
   input  logic [FIELD_BITS-1:0]     req_vertex_b,
   input  logic [FIELD_BITS-1:0]     req_vertex_c,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_hit,
   output logic [2:0]                rsp_cause,
   // register write channel
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [FIELD_BITS-1:0]     csr_data
);

   // configuration registers
   logic [FIELD_BITS-1:0] row_x_ff, row_y_ff, row_z_ff, translation_ff;
   logic [LIMIT_BITS-1:0] near_limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_x_ff       <= ROW_X_RESET;
         row_y_ff       <= ROW_Y_RESET;
         row_z_ff       <= ROW_Z_RESET;
         translation_ff <= TRANSLATION_RESET;
         near_limit_ff  <= NEAR_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROW_X:       row_x_ff       <= csr_data;
            CSR_ROW_Y:       row_y_ff       <= csr_data;
            CSR_ROW_Z:       row_z_ff       <= csr_data;
            CSR_TRANSLATION: translation_ff <= csr_data;
            CSR_NEAR_LIMIT:  near_limit_ff  <= csr_data[LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // stage valid chain; a stage loads when it is empty or its successor moves
   logic [NUM_STAGES-1:0] valid_ff, valid_in, en;

   always_comb begin
      en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in[0] = en[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   // datapath
   logic signed [COORD_BITS-1:0]   s_x [3], e_x [3], a_x [3], b_x [3], c_x [3];
   logic                           nomo_x;
   logic signed [COORD_BITS:0]     d_g [3], r_g [3];
   logic signed [2*COORD_BITS+2:0] n_g [3], q_g [3], w_g [3];
   flags_type                      flags_g;
   cause_type                      cause_s;

   sttc_xform #(.COORD_BITS(COORD_BITS)) u_xform (
      .clock         (clock),
      .en            (en[1:0]),
      .segment_start (req_segment_start),
      .segment_end   (req_segment_end),
      .vertex_a      (req_vertex_a),
      .vertex_b      (req_vertex_b),
      .vertex_c      (req_vertex_c),
      .row_x         (row_x_ff),
      .row_y         (row_y_ff),
      .row_z         (row_z_ff),
      .translation   (translation_ff),
      .s_o           (s_x),
      .e_o           (e_x),
      .a_o           (a_x),
      .b_o           (b_x),
      .c_o           (c_x),
      .no_motion_o   (nomo_x)
   );

   sttc_geom #(.COORD_BITS(COORD_BITS)) u_geom (
      .clock       (clock),
      .en          (en[4:2]),
      .s_i         (s_x),
      .e_i         (e_x),
      .a_i         (a_x),
      .b_i         (b_x),
      .c_i         (c_x),
      .no_motion_i (nomo_x),
      .near_limit  (near_limit_ff),
      .d_o         (d_g),
      .r_o         (r_g),
      .n_o         (n_g),
      .q_o         (q_g),
      .w_o         (w_g),
      .flags_o     (flags_g)
   );

   sttc_solve #(.COORD_BITS(COORD_BITS)) u_solve (
      .clock   (clock),
      .en      (en[7:5]),
      .d_i     (d_g),
      .r_i     (r_g),
      .n_i     (n_g),
      .q_i     (q_g),
      .w_i     (w_g),
      .flags_i (flags_g),
      .hit_o   (rsp_hit),
      .cause_o (cause_s)
   );

   assign rsp_cause = cause_s;

`ifndef NO_ASSERTIONS
   // an accepted request shows up in the first stage
   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_ff[0])
      else $error("accepted request not captured");

   // hit flag agrees with the cause code
   a_hit_cause : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hit == (cause_s == CAUSE_NEAR || cause_s == CAUSE_CROSS)))
      else $error("hit and cause disagree");

   // a full pipeline with a stalled output takes no request
   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      (&valid_ff) && !rsp_ready |-> !req_ready)
      else $error("request taken while pipeline full");
`endif

endmodule

// ===== dv/sttc_checker.sv =====
// ----------------------------------------------------------------------------
// sttc_checker
// watches the request, response and register channels of the crossing test,
// predicts each response from its own register copy and compares in order
// ----------------------------------------------------------------------------
module sttc_checker import sttc_pkg::*; #(
   parameter int COORD_BITS = 21
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [FIELD_BITS-1:0]     req_segment_start,
   input  logic [FIELD_BITS-1:0]     req_segment_end,
   input  logic [FIELD_BITS-1:0]     req_vertex_a,
   input  logic [FIELD_BITS-1:0]     req_vertex_b,
   input  logic [FIELD_BITS-1:0]     req_vertex_c,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic                      rsp_hit,
   input  logic [2:0]                rsp_cause,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [FIELD_BITS-1:0]     csr_data,
   output int                        fail_count,
   output int                        pending_count
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [127:0] wide_type;
   typedef struct {
      logic      hit;
      cause_type cause;
   } verdict_type;

   logic [FIELD_BITS-1:0] row_x, row_y, row_z, translation;
   logic [LIMIT_BITS-1:0] near_limit;
   verdict_type           expected_verdicts[$];
   int                    mismatches = 0;

   assign fail_count    = mismatches;
   assign pending_count = expected_verdicts.size();

   function automatic longint slot_value(logic [FIELD_BITS-1:0] word, int slot, int width);
      longint v;
      v = longint'(word >> (slot * width)) & ((64'sd1 <<< width) - 1);
      if (v[width-1])
         v = v - (64'sd1 <<< width);
      return v;
   endfunction

   function automatic longint map_coord(logic [FIELD_BITS-1:0] corner, int axis);
      logic [FIELD_BITS-1:0] row;
      longint acc;
      longint lim_hi;
      row = (axis == 0) ? row_x : (axis == 1) ? row_y : row_z;
      acc = slot_value(translation, axis, COORD_BITS) * (64'sd1 <<< COEF_FRAC);
      for (int j = 0; j < 3; j++)
         acc += slot_value(row, j, COEF_BITS) * slot_value(corner, j, COORD_BITS);
      acc += 64'sd1 <<< (COEF_FRAC - 1);
      acc = acc >>> COEF_FRAC;
      lim_hi = (64'sd1 <<< (COORD_BITS - 1)) - 1;
      if (acc > lim_hi) return lim_hi;
      if (acc < -lim_hi - 1) return -lim_hi - 1;
      return acc;
   endfunction

   function automatic wide_type dot(longint x[3], longint y[3]);
      wide_type sum;
      sum = 0;
      for (int i = 0; i < 3; i++)
         sum += wide_type'(x[i]) * wide_type'(y[i]);
      return sum;
   endfunction

   function automatic void cross_prod(longint x[3], longint y[3], output longint o[3]);
      o[0] = x[1] * y[2] - x[2] * y[1];
      o[1] = x[2] * y[0] - x[0] * y[2];
      o[2] = x[0] * y[1] - x[1] * y[0];
   endfunction

   function automatic verdict_type judge_crossing(logic [FIELD_BITS-1:0] seg_from,
         logic [FIELD_BITS-1:0] seg_to, logic [FIELD_BITS-1:0] va,
         logic [FIELD_BITS-1:0] vb, logic [FIELD_BITS-1:0] vc);
      verdict_type v;
      longint s[3], e[3], a[3], b[3], c[3];
      longint d[3], e1[3], e2[3], r[3], n[3], q[3], w[3];
      longint dist2, lim, k;
      wide_type det, tn, un, vn;
      dist2 = 0;
      lim = longint'(near_limit);
      for (int i = 0; i < 3; i++) begin
         s[i] = slot_value(seg_from, i, COORD_BITS);
         e[i] = slot_value(seg_to, i, COORD_BITS);
      end
      if (s[0] == e[0] && s[1] == e[1] && s[2] == e[2]) begin
         v.hit = 1'b0; v.cause = CAUSE_NO_MOTION;
         return v;
      end
      for (int i = 0; i < 3; i++) begin
         a[i] = map_coord(va, i);
         b[i] = map_coord(vb, i);
         c[i] = map_coord(vc, i);
      end
      for (int i = 0; i < 3; i++) begin
         k = e[i] - a[i];
         dist2 += k * k;
         d[i] = s[i] - e[i];
         e1[i] = b[i] - a[i];
         e2[i] = c[i] - a[i];
         r[i] = s[i] - a[i];
      end
      if (dist2 < lim * lim) begin
         v.hit = 1'b1; v.cause = CAUSE_NEAR;
         return v;
      end
      cross_prod(e1, e2, n);
      cross_prod(r, e2, q);
      cross_prod(e1, r, w);
      det = dot(d, n);
      tn = dot(r, n);
      un = dot(d, q);
      vn = dot(d, w);
      if (det == 0) begin
         v.hit = 1'b0; v.cause = CAUSE_DEGENERATE;
         return v;
      end
      if (det < 0) begin
         det = -det; tn = -tn; un = -un; vn = -vn;
      end
      if (tn >= 0 && tn <= det && un >= 0 && un <= det && vn >= 0 && vn <= det
          && un + vn <= det) begin
         v.hit = 1'b1; v.cause = CAUSE_CROSS;
      end else begin
         v.hit = 1'b0; v.cause = CAUSE_MISS;
      end
      return v;
   endfunction

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         row_x       <= ROW_X_RESET;
         row_y       <= ROW_Y_RESET;
         row_z       <= ROW_Z_RESET;
         translation <= TRANSLATION_RESET;
         near_limit  <= NEAR_LIMIT_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROW_X:       row_x <= csr_data;
               CSR_ROW_Y:       row_y <= csr_data;
               CSR_ROW_Z:       row_z <= csr_data;
               CSR_TRANSLATION: translation <= csr_data;
               CSR_NEAR_LIMIT:  near_limit <= csr_data[LIMIT_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_verdicts.push_back(judge_crossing(req_segment_start, req_segment_end,
                                                       req_vertex_a, req_vertex_b,
                                                       req_vertex_c));
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%t: response with nothing pending, hit %0b cause %0d",
                           $realtime, rsp_hit, rsp_cause);
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_hit !== want.hit || rsp_cause !== want.cause) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%t: mismatch, expected hit %0b cause %0d, got hit %0b cause %0d",
                              $realtime, want.hit, want.cause, rsp_hit, rsp_cause);
               end
            end
         end
      end
   end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the segment / triangle crossing test: directed
// corner cases, then random segments and triangles over several register
// settings and idle patterns, checked by sttc_checker
// ----------------------------------------------------------------------------
module tb_top import sttc_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_BITS = 21;
   // index past the register list, writes there must be ignored
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 3'd7;
   localparam int NUM_PHASES = 6;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [FIELD_BITS-1:0]     req_segment_start = '0;
   logic [FIELD_BITS-1:0]     req_segment_end = '0;
   logic [FIELD_BITS-1:0]     req_vertex_a = '0;
   logic [FIELD_BITS-1:0]     req_vertex_b = '0;
   logic [FIELD_BITS-1:0]     req_vertex_c = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_hit;
   logic [2:0]                rsp_cause;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_ROW_X;
   logic [FIELD_BITS-1:0]     csr_data = '0;
   int                        fail_count;
   int                        pending_count;

   // idle percentages, changed per phase
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   // cycles the receiver still has to hold off
   int hold_len = 0;
   int requests_sent = 0;

   segment_triangle_crossing_test_top #(.COORD_BITS(COORD_BITS)) i_dut (.*);

   sttc_checker #(.COORD_BITS(COORD_BITS)) i_checker (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // generous cap on the run
   initial begin
      #4ms;
      $display("simulation failed");
      $finish;
   end

   // receiver: random stalls, or a long hold-off when asked for
   initial begin
      forever begin
         @(posedge clock);
         if (hold_len > 0) begin
            rsp_ready <= 1'b0;
            hold_len--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // pack three signed coordinates, x in the lowest slot
   function automatic logic [FIELD_BITS-1:0] pack(int x, int y, int z);
      logic [COORD_BITS-1:0] px, py, pz;
      px = COORD_BITS'(x); py = COORD_BITS'(y); pz = COORD_BITS'(z);
      return {pz, py, px};
   endfunction

   function automatic int rand_coord(int span);
      return $urandom_range(2 * span) - span;
   endfunction

   function automatic logic [FIELD_BITS-1:0] rand_word();
      return FIELD_BITS'({$urandom, $urandom});
   endfunction

   // pack three signed matrix coefficients, column 0 lowest
   function automatic logic [FIELD_BITS-1:0] coefs(int c0, int c1, int c2);
      logic [COEF_BITS-1:0] p0, p1, p2;
      p0 = COEF_BITS'(c0); p1 = COEF_BITS'(c1); p2 = COEF_BITS'(c2);
      return {p2, p1, p0};
   endfunction

   task automatic send_request(logic [FIELD_BITS-1:0] s, logic [FIELD_BITS-1:0] e,
                               logic [FIELD_BITS-1:0] a, logic [FIELD_BITS-1:0] b,
                               logic [FIELD_BITS-1:0] c);
      // random gap before the request, valid low meanwhile
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_segment_start <= s;
      req_segment_end   <= e;
      req_vertex_a      <= a;
      req_vertex_b      <= b;
      req_vertex_c      <= c;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   // stop offering and wait for every response, then let the pipe empty
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // csr_valid stays high afterwards, the caller drops it
   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] index, logic [FIELD_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_matrix(logic [FIELD_BITS-1:0] rx, logic [FIELD_BITS-1:0] ry,
                             logic [FIELD_BITS-1:0] rz, logic [FIELD_BITS-1:0] tr,
                             int near);
      write_csr(CSR_ROW_X, rx);
      write_csr(CSR_ROW_Y, ry);
      write_csr(CSR_ROW_Z, rz);
      write_csr(CSR_TRANSLATION, tr);
      write_csr(CSR_NEAR_LIMIT, FIELD_BITS'(near));
   endtask

   // one random request, mostly shaped to reach the crossing solve
   task automatic random_request();
      logic [FIELD_BITS-1:0] a, b, c, s, e;
      int kind, span, px, py, pz, hz;
      kind = $urandom_range(99);
      span = ($urandom_range(9) == 0) ? 1000000 : 4000;
      // triangle roughly in the z = 0 plane, tilted a bit
      a = pack(rand_coord(span), rand_coord(span), rand_coord(span / 8));
      b = pack(rand_coord(span), rand_coord(span), rand_coord(span / 8));
      c = pack(rand_coord(span), rand_coord(span), rand_coord(span / 8));
      px = rand_coord(span / 2);
      py = rand_coord(span / 2);
      pz = rand_coord(span / 8);
      hz = $urandom_range(span, 1);
      s = pack(px, py, pz + hz);
      e = pack(px + rand_coord(64), py + rand_coord(64), pz - $urandom_range(span, 1));
      if (kind < 15) begin
         // noise across every bit
         s = rand_word(); e = rand_word();
         a = rand_word(); b = rand_word(); c = rand_word();
      end else if (kind < 23) begin
         e = s;
      end else if (kind < 33) begin
         // end point close to the first corner when the map is near identity
         e = a + pack(rand_coord(4), rand_coord(4), rand_coord(4));
      end else if (kind < 38) begin
         // segment parallel to a flat triangle, or a collapsed triangle
         a[62:42] = 0; b[62:42] = 0; c[62:42] = 0;
         if ($urandom_range(1)) c = b;
         else e = pack(px + rand_coord(span), py, pz + hz);
         if (!$urandom_range(1)) s = pack(px, py, pz + hz);
      end
      send_request(s, e, a, b, c);
   endtask

   initial begin
      int per_phase;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part under the reset registers (identity map, near 3.0)
      // triangle A=(0,0,0) B=(10,0,0) C=(0,10,0)
      send_request(pack(512, 512, 1280), pack(512, 512, -1280),
                   pack(0, 0, 0), pack(2560, 0, 0), pack(0, 2560, 0));
      // start on the plane: t at zero
      send_request(pack(512, 512, 0), pack(512, 512, -1280),
                   pack(0, 0, 0), pack(2560, 0, 0), pack(0, 2560, 0));
      // end on the plane: t at one
      send_request(pack(512, 512, 1280), pack(1024, 1024, 0),
                   pack(0, 0, 0), pack(2560, 0, 0), pack(0, 2560, 0));
      // through the hypotenuse: u + v exactly one
      send_request(pack(1280, 1280, 640), pack(1280, 1280, -640),
                   pack(0, 0, 0), pack(2560, 0, 0), pack(0, 2560, 0));
      // through corner B and along edge AB
      send_request(pack(2560, 0, 640), pack(2560, 0, -640),
                   pack(0, 0, 0), pack(2560, 0, 0), pack(0, 2560, 0));
      send_request(pack(1000, 0, 640), pack(1000, 0, -640),
                   pack(0, 0, 0), pack(2560, 0, 0), pack(0, 2560, 0));
      // outside the triangle, and segment stopping short of the plane
      send_request(pack(2000, 2000, 640), pack(2000, 2000, -640),
                   pack(0, 0, 0), pack(2560, 0, 0), pack(0, 2560, 0));
      send_request(pack(512, 512, 1280), pack(512, 512, 640),
                   pack(0, 0, 0), pack(2560, 0, 0), pack(0, 2560, 0));
      // parallel segment and collapsed triangle: degenerate system
      send_request(pack(512, 512, 256), pack(1024, 512, 256),
                   pack(0, 0, 0), pack(2560, 0, 0), pack(0, 2560, 0));
      send_request(pack(512, 512, 1280), pack(512, 512, -1280),
                   pack(0, 0, 0), pack(2560, 0, 0), pack(2560, 0, 0));
      // nearness just inside and exactly on the limit
      send_request(pack(1000, 1000, 1000), pack(767, 0, 0),
                   pack(0, 0, 0), pack(2560, 0, 0), pack(0, 2560, 0));
      send_request(pack(1000, 1000, 1000), pack(768, 0, 0),
                   pack(0, 0, 0), pack(2560, 0, 0), pack(0, 2560, 0));
      // no motion at the field extremes
      send_request('0, '0, '0, '0, '0);
      send_request('1, '1, '1, '1, '1);
      send_request(pack(1048575, -1048576, 1048575), pack(1048575, -1048576, 1048575),
                   '1, '0, '1);
      // extreme coordinates, saturating corners
      send_request(pack(1048575, 1048575, 1048575), pack(-1048576, -1048576, -1048576),
                   pack(-1048576, -1048576, 0), pack(1048575, -1048576, 0),
                   pack(0, 1048575, 0));
      send_request({FIELD_BITS{1'b1}} >> 1, {1'b1, {(FIELD_BITS-1){1'b0}}},
                   '1, '0, {FIELD_BITS{1'b1}} >> 1);
      send_request(pack(-1048576, 0, 1048575), pack(1048575, 0, -1048576),
                   pack(0, -1048576, 0), pack(0, 1048575, 1048575),
                   pack(1048575, 0, -1048576));
      drain();

      // random phases, each with its own registers and idle pattern
      per_phase = 630 / NUM_PHASES;
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: set_matrix(ROW_X_RESET, ROW_Y_RESET, ROW_Z_RESET, TRANSLATION_RESET,
                          NEAR_LIMIT_RESET);
            // identity with a shift and a tight near limit
            1: set_matrix(coefs(4096, 0, 0), coefs(0, 4096, 0), coefs(0, 0, 4096),
                          pack(2560, -1280, 768), 1);
            // axes swapped, scaled and mirrored, rounding on halves
            2: set_matrix(coefs(0, 8192, 2048), coefs(-2048, 0, -4096),
                          coefs(4096, 1, 0), pack(-3, 5, 0), 0);
            // coefficient and translation extremes, widest near limit
            3: set_matrix(coefs(1048575, 1048575, 1048575),
                          coefs(-1048576, -1048576, -1048576),
                          coefs(1048575, -1048576, 1048575),
                          pack(1048575, -1048576, 1048575), 1048575);
            4: begin
               set_matrix(coefs(-1048576, 0, 0), coefs(0, -4096, 0), coefs(0, 0, 2048),
                          pack(-1048576, 1048575, -1048576), 256);
               write_csr(CSR_UNUSED, '1);
            end
            default: set_matrix(coefs(4096, -2, 3), coefs(5, 4095, -7),
                                coefs(1, 1, 4097), pack(7, -9, 11), 768);
         endcase
         csr_valid <= 1'b0;
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 60; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 60; end
            default: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
         endcase
         for (int n = 0; n < per_phase; n++) begin
            // long receiver hold-off while the sender keeps offering
            if (phase == 1 && n == 20) begin
               sender_idle_pct = 0;
               hold_len = 300;
            end
            if (phase == 1 && n == 60) sender_idle_pct = 60;
            random_request();
         end
         drain();
      end

      $display("sent %0d requests: directed corners, then random segments over %0d",
               requests_sent, NUM_PHASES);
      $display("register settings with idle, stall and long hold-off patterns");
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/sttc_pkg.sv
design/sttc_xform.sv
design/sttc_geom.sv
design/sttc_solve.sv
design/segment_triangle_crossing_test_top.sv
dv/sttc_checker.sv
dv/tb_top.sv
